@@ rtl/disc_lba_track_translation_macros.svh @@
// Assertion macros shared by the checker of the track translation block.
// No dependencies; take it in by `include with the bare file name.
`ifndef DISC_LBA_TRACK_TRANSLATION_MACROS_SVH
`define DISC_LBA_TRACK_TRANSLATION_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DLT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("track translation check failed");

// Check a property on every rising clock edge, reset included.
`define DLT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("track translation check failed");

`endif

@@ rtl/dlt_pkg.sv @@
// Shared types and constants of the disc LBA track translation block.
// No dependencies; the files that use it refer to it by scoped names.
package dlt_pkg;

  localparam int unsigned MAX_TRACKS_DEF = 128;
  localparam int unsigned LBA_BITS_DEF   = 20;

  localparam int unsigned SECTOR_W = 20;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FILE_W   = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BYTE_W   = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned SIZE_W   = 12;

  localparam logic [SIZE_W-1:0] SHORT_SECTOR_BYTES = 12'd2048;
  localparam logic [SIZE_W-1:0] LONG_SECTOR_BYTES  = 12'd2352;

  localparam logic [MODE_W-1:0] MODE_AUDIO = 2'd2;

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_TRACK     = 2'd1,
    STATUS_AUDIO        = 2'd2,
    STATUS_BEFORE_START = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_TRACK_COUNT   = 2'd0,
    REG_MULTI_FILE    = 2'd1,
    REG_PREGAP_STORED = 2'd2
  } reg_e;

  // One track table entry as it sits in the RAM word.
  typedef struct packed {
    logic [FILE_W-1:0]   file;
    logic                short_sectors;
    logic [MODE_W-1:0]   mode;
    logic [SECTOR_W-1:0] pregap;
    logic [SECTOR_W-1:0] file_offset;
    logic [SECTOR_W-1:0] start;
  } entry_t;

endpackage

@@ rtl/dlt_req_if.sv @@
// Request channel of the track translation block: table loads and lookups.
// Depends on dlt_pkg for field widths.
interface dlt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [dlt_pkg::SLOT_W-1:0]    entry_slot;
  logic [dlt_pkg::SECTOR_W-1:0]  entry_start;
  logic [dlt_pkg::SECTOR_W-1:0]  entry_file_offset;
  logic [dlt_pkg::SECTOR_W-1:0]  entry_pregap;
  logic [dlt_pkg::MODE_W-1:0]    entry_mode;
  logic                          entry_short_sectors;
  logic [dlt_pkg::FILE_W-1:0]    entry_file;
  logic [dlt_pkg::SECTOR_W-1:0]  query_lba;

  modport source (
    output valid, operation, entry_slot, entry_start, entry_file_offset,
           entry_pregap, entry_mode, entry_short_sectors, entry_file, query_lba,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_slot, entry_start, entry_file_offset,
           entry_pregap, entry_mode, entry_short_sectors, entry_file, query_lba,
    output ready
  );
endinterface

@@ rtl/dlt_rsp_if.sv @@
// Result channel of the track translation block.
// Depends on dlt_pkg for field widths.
interface dlt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dlt_pkg::STATUS_W-1:0]  status;
  logic [dlt_pkg::SLOT_W-1:0]    found_slot;
  logic [dlt_pkg::MODE_W-1:0]    found_mode;
  logic [dlt_pkg::FILE_W-1:0]    found_file;
  logic [dlt_pkg::SECTOR_W-1:0]  file_sector;
  logic                          found_short_sectors;
  logic [dlt_pkg::BYTE_W-1:0]    byte_offset;

  modport source (
    output valid, status, found_slot, found_mode, found_file, file_sector,
           found_short_sectors, byte_offset,
    input  ready
  );

  modport sink (
    input  valid, status, found_slot, found_mode, found_file, file_sector,
           found_short_sectors, byte_offset,
    output ready
  );
endinterface

@@ rtl/dlt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dlt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/disc_lba_track_translation.sv @@
// Disc LBA to file sector translation: track table in RAM, scanned per lookup.
// Depends on dlt_pkg, dlt_req_if, dlt_rsp_if and dlt_ram.
//
// Usage:
//   req_i carries one transaction per item: a load writes one track entry
//   into slot entry_slot, a lookup translates query_lba. rsp_o returns one
//   transaction per item, in order. The APB port sets track_count (0x0),
//   multi_file (0x4) and pregap_stored (0x8); write it only while idle.
//   A load goes to the emit state and from there into the output register.
//   A lookup reads the track table through one RAM port, one entry per
//   cycle, then computes the result in the calc state before it is emitted.
//   One item is in work at a time; req_i.ready rises again once the result
//   sits in the output register.
//   Reset clears the registers to track_count 0, multi_file 0,
//   pregap_stored 1 and empties the output register. The table RAM is not
//   cleared; slots below track_count must be loaded before a lookup.
//   When rsp_o stalls, the result holds in the output register and the
//   block still accepts and works the next item, then waits for the slot.
module disc_lba_track_translation #(
  parameter int unsigned MAX_TRACKS = dlt_pkg::MAX_TRACKS_DEF,
  parameter int unsigned LBA_BITS   = dlt_pkg::LBA_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dlt_req_if.sink                       req_i,
  dlt_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlt_pkg::PADDR_W-1:0]   paddr,
  input  logic [dlt_pkg::PDATA_W-1:0]   pwdata,
  output logic [dlt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TRACKS + 1);
  localparam int unsigned GW = dlt_pkg::SECTOR_W + CW;
  localparam int unsigned SW = dlt_pkg::SECTOR_W + 1;
  localparam int unsigned EW = $bits(dlt_pkg::entry_t);
  localparam logic [32:0] LbaMax = (33'd1 << LBA_BITS) - 33'd1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CALC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Configuration registers
  logic [dlt_pkg::COUNT_W-1:0] track_count_q;
  logic                        multi_file_q;
  logic                        pregap_stored_q;
  logic                        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_count_q   <= '0;
      multi_file_q    <= 1'b0;
      pregap_stored_q <= 1'b1;
    end else if (cfg_we) begin
      case (dlt_pkg::reg_e'(paddr[3:2]))
        dlt_pkg::REG_TRACK_COUNT:   track_count_q   <= pwdata[dlt_pkg::COUNT_W-1:0];
        dlt_pkg::REG_MULTI_FILE:    multi_file_q    <= pwdata[0];
        dlt_pkg::REG_PREGAP_STORED: pregap_stored_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (dlt_pkg::reg_e'(paddr[3:2]))
      dlt_pkg::REG_TRACK_COUNT:   prdata = dlt_pkg::PDATA_W'(track_count_q);
      dlt_pkg::REG_MULTI_FILE:    prdata = dlt_pkg::PDATA_W'(multi_file_q);
      dlt_pkg::REG_PREGAP_STORED: prdata = dlt_pkg::PDATA_W'(pregap_stored_q);
      default:                    prdata = '0;
    endcase
  end

  // Number of live table entries, clamped to the table depth
  logic [CW-1:0] n_valid;
  assign n_valid = (32'(track_count_q) > MAX_TRACKS) ? CW'(MAX_TRACKS)
                                                     : CW'(track_count_q);

  // Control state
  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rvalid_q, rvalid_d;
  logic          found_q, found_d;
  logic          brk_q, brk_d;
  logic          out_valid_q, out_valid_d;

  // Payload state
  logic [AW-1:0]               ridx_q, ridx_d;
  logic [dlt_pkg::SECTOR_W-1:0] lba_q, lba_d;
  dlt_pkg::entry_t             best_q, best_d;
  logic [AW-1:0]               best_idx_q, best_idx_d;
  logic [GW-1:0]               gap_q, gap_d;

  dlt_pkg::status_e            res_status_q, res_status_d;
  logic [dlt_pkg::SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic [dlt_pkg::MODE_W-1:0]  res_mode_q, res_mode_d;
  logic [dlt_pkg::FILE_W-1:0]  res_file_q, res_file_d;
  logic                        res_short_q, res_short_d;
  logic [SW-1:0]               res_sector_q, res_sector_d;

  dlt_pkg::status_e             out_status_q, out_status_d;
  logic [dlt_pkg::SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [dlt_pkg::MODE_W-1:0]   out_mode_q, out_mode_d;
  logic [dlt_pkg::FILE_W-1:0]   out_file_q, out_file_d;
  logic [dlt_pkg::SECTOR_W-1:0] out_sector_q, out_sector_d;
  logic                         out_short_q, out_short_d;
  logic [dlt_pkg::BYTE_W-1:0]   out_bytes_q, out_bytes_d;

  // Table RAM
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  dlt_pkg::entry_t ram_wdata, ram_rentry;
  logic [EW-1:0]   ram_rdata;

  dlt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TRACKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_rentry = dlt_pkg::entry_t'(ram_rdata);

  logic req_fire;
  logic emit_free;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign emit_free   = !out_valid_q || rsp_o.ready;

  always_comb begin
    ram_we    = req_fire && (req_i.operation == dlt_pkg::OP_LOAD) &&
                (32'(req_i.entry_slot) < MAX_TRACKS);
    ram_waddr = AW'(req_i.entry_slot);
    ram_wdata.start         = req_i.entry_start;
    ram_wdata.file_offset   = req_i.entry_file_offset;
    ram_wdata.pregap        = req_i.entry_pregap;
    ram_wdata.mode          = req_i.entry_mode;
    ram_wdata.short_sectors = req_i.entry_short_sectors;
    ram_wdata.file          = req_i.entry_file;
    ram_re    = (state_q == ST_SCAN) && (cnt_q < n_valid);
    ram_raddr = cnt_q[AW-1:0];
  end

  // Final sector arithmetic on the chosen entry
  logic [dlt_pkg::SECTOR_W-1:0] lba_span;
  logic [SW-1:0]                msum, msat, ssub;
  logic                         gap_over;
  logic [dlt_pkg::SIZE_W-1:0]   sec_size;
  logic [32:0]                  prod;

  always_comb begin
    lba_span = lba_q - best_q.start;
    msum     = {1'b0, best_q.file_offset} + {1'b0, lba_span};
    msat     = (33'(msum) > LbaMax) ? LbaMax[SW-1:0] : msum;
    gap_over = 33'(gap_q) > 33'(lba_q);
    ssub     = {1'b0, lba_q} - SW'(gap_q);
    sec_size = res_short_q ? dlt_pkg::SHORT_SECTOR_BYTES : dlt_pkg::LONG_SECTOR_BYTES;
    prod     = 33'(res_sector_q) * 33'(sec_size);
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    rvalid_d     = 1'b0;
    ridx_d       = cnt_q[AW-1:0];
    found_d      = found_q;
    brk_d        = brk_q;
    lba_d        = lba_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    gap_d        = gap_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_mode_d   = res_mode_q;
    res_file_d   = res_file_q;
    res_short_d  = res_short_q;
    res_sector_d = res_sector_q;

    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_mode_d   = out_mode_q;
    out_file_d   = out_file_q;
    out_sector_d = out_sector_q;
    out_short_d  = out_short_q;
    out_bytes_d  = out_bytes_q;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          lba_d = req_i.query_lba & LbaMax[dlt_pkg::SECTOR_W-1:0];
          if (req_i.operation == dlt_pkg::OP_LOAD) begin
            res_status_d = dlt_pkg::STATUS_OK;
            res_slot_d   = '0;
            res_mode_d   = '0;
            res_file_d   = '0;
            res_short_d  = 1'b0;
            res_sector_d = '0;
            state_d      = ST_EMIT;
          end else begin
            cnt_d   = '0;
            found_d = 1'b0;
            brk_d   = 1'b0;
            gap_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (ram_re) begin
          cnt_d    = cnt_q + CW'(1);
          rvalid_d = 1'b1;
        end
        if (rvalid_q) begin
          // later slot wins on an equal start
          if ((ram_rentry.start <= lba_q) &&
              (!found_q || (ram_rentry.start >= best_q.start))) begin
            found_d    = 1'b1;
            best_d     = ram_rentry;
            best_idx_d = ridx_q;
          end
          // pregaps sum up to the first track that starts past the LBA
          if (!brk_q) begin
            if (ram_rentry.start > lba_q) begin
              brk_d = 1'b1;
            end else begin
              gap_d = gap_q + GW'(ram_rentry.pregap);
            end
          end
        end
        if (!ram_re && !rvalid_q) begin
          state_d = ST_CALC;
        end
      end

      ST_CALC: begin
        res_slot_d   = dlt_pkg::SLOT_W'(best_idx_q);
        res_mode_d   = best_q.mode;
        res_file_d   = best_q.file;
        res_short_d  = best_q.short_sectors;
        res_sector_d = '0;
        if (!found_q) begin
          res_status_d = dlt_pkg::STATUS_NO_TRACK;
          res_slot_d   = '0;
          res_mode_d   = '0;
          res_file_d   = '0;
          res_short_d  = 1'b0;
        end else if (best_q.mode == dlt_pkg::MODE_AUDIO) begin
          res_status_d = dlt_pkg::STATUS_AUDIO;
        end else if (multi_file_q) begin
          res_status_d = dlt_pkg::STATUS_OK;
          res_sector_d = msat;
        end else if (!pregap_stored_q && gap_over) begin
          res_status_d = dlt_pkg::STATUS_BEFORE_START;
        end else if (!pregap_stored_q) begin
          res_status_d = dlt_pkg::STATUS_OK;
          res_sector_d = ssub;
        end else begin
          res_status_d = dlt_pkg::STATUS_OK;
          res_sector_d = {1'b0, lba_q};
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        // hold until the output register frees up
        if (emit_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_mode_d   = res_mode_q;
          out_file_d   = res_file_q;
          out_sector_d = res_sector_q[dlt_pkg::SECTOR_W-1:0];
          out_short_d  = res_short_q;
          out_bytes_d  = prod[dlt_pkg::BYTE_W-1:0];
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rvalid_q    <= 1'b0;
      found_q     <= 1'b0;
      brk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rvalid_q    <= rvalid_d;
      found_q     <= found_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= ridx_d;
    lba_q        <= lba_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    gap_q        <= gap_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_mode_q   <= res_mode_d;
    res_file_q   <= res_file_d;
    res_short_q  <= res_short_d;
    res_sector_q <= res_sector_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_mode_q   <= out_mode_d;
    out_file_q   <= out_file_d;
    out_sector_q <= out_sector_d;
    out_short_q  <= out_short_d;
    out_bytes_q  <= out_bytes_d;
  end

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.status              = out_status_q;
  assign rsp_o.found_slot          = out_slot_q;
  assign rsp_o.found_mode          = out_mode_q;
  assign rsp_o.found_file          = out_file_q;
  assign rsp_o.file_sector         = out_sector_q;
  assign rsp_o.found_short_sectors = out_short_q;
  assign rsp_o.byte_offset         = out_bytes_q;

endmodule

@@ rtl/dlt_checker.sv @@
// Port-level checks of the track translation block, bound to its top level.
// Depends on dlt_pkg and disc_lba_track_translation_macros.svh.
`include "disc_lba_track_translation_macros.svh"

module dlt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          req_operation,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [dlt_pkg::STATUS_W-1:0]  rsp_status,
  input logic [dlt_pkg::SECTOR_W-1:0]  rsp_file_sector,
  input logic [dlt_pkg::BYTE_W-1:0]    rsp_byte_offset,
  input logic                          pready
);

  // Reset empties the output register.
  `DLT_ASSERT_ALWAYS(a_rsp_idle_in_reset, clk_i, !rst_ni |=> !rsp_valid)

  // A stalled result stays offered.
  `DLT_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready |=> rsp_valid)

  // One item in work at a time: no transaction right after another.
  `DLT_ASSERT(a_one_in_work, clk_i, rst_ni, req_valid && req_ready |=> !req_ready)

  // A load into an empty output answers ok once it has passed the emit state.
  `DLT_ASSERT(a_load_answer, clk_i, rst_ni,
    req_valid && req_ready && (req_operation == dlt_pkg::OP_LOAD) && !rsp_valid && pready
      |=> ##1 (rsp_valid && (rsp_status == dlt_pkg::STATUS_OK)))

  // Only a good translation carries a sector and byte offset.
  `DLT_ASSERT(a_zero_on_fail, clk_i, rst_ni,
    rsp_valid && (rsp_status != dlt_pkg::STATUS_OK)
      |-> (rsp_file_sector == '0) && (rsp_byte_offset == '0))

endmodule

bind disc_lba_track_translation dlt_checker u_dlt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .req_operation   (req_i.operation),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .rsp_status      (rsp_o.status),
  .rsp_file_sector (rsp_o.file_sector),
  .rsp_byte_offset (rsp_o.byte_offset),
  .pready          (pready)
);
